// File: design/fpsg_pkg.sv
// ----------------------------------------------------------------------------
// fpsg_pkg: shared types and constants for the frame pacing skip governor
// Field widths, register indexes, pacing codes, the phase offset table and the
// stage record passed between the decision and rate stages.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsg_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int SKIP_W  = 8;
   localparam int MODE_W  = 2;
   localparam int FPS_W   = 16;
   localparam int FRAME_W = 32;
   localparam int PHASE_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Phase table length (3 to 64)
   localparam int PHASES = 60;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SKIP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_MID   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_HIGH  = 2'd2;

   // Register reset values
   localparam logic [SKIP_W-1:0]  MAX_SKIP_RST = 8'd20;
   localparam logic [COUNT_W-1:0] THR_MID_RST  = 16'd1000;
   localparam logic [COUNT_W-1:0] THR_HIGH_RST = 16'd2000;

   // Pacing codes
   localparam logic [MODE_W-1:0] MODE_60 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_40 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_30 = 2'd2;

   // Deadline offsets in ms
   localparam logic [5:0] OFF_60_A = 6'd17;
   localparam logic [5:0] OFF_60_B = 6'd16;
   localparam logic [5:0] OFF_40   = 6'd25;
   localparam logic [5:0] OFF_30_A = 6'd33;
   localparam logic [5:0] OFF_30_B = 6'd34;

   localparam logic [7:0]        START_LEAD = 8'd100;
   localparam logic [TIME_W-1:0] FPS_PERIOD = 32'd1000;

   // Rate math: fps = floor((d * 256 * off0 + 8) / 17), off0 in {17,25,33}.
   // Split 256*off0 = 17*a + r, so fps = d*a + floor((d*r + 8) / 17).
   localparam int FPS_D_W = 13;
   localparam logic [TIME_W-1:0] FPS_SAT_D = 32'd4352;   // d*off0 >= 4352 saturates
   localparam logic [8:0]  FPS_A_60 = 9'd256;
   localparam logic [8:0]  FPS_A_40 = 9'd376;
   localparam logic [8:0]  FPS_A_30 = 9'd496;
   localparam logic [16:0] FPS_ROUND   = 17'd8;
   localparam logic [16:0] FPS_DIV_MUL = 17'd123362;   // ceil(2^21 / 17)
   localparam int          FPS_DIV_SH  = 21;

   // Decision stage record
   typedef struct packed {
      logic                 stepped;
      logic                 prepared;
      logic                 presented;
      logic                 finalized;
      logic [MODE_W-1:0]    mode;
      logic                 fps_upd;
      logic                 d_big;
      logic [FPS_D_W-1:0]   d_small;
      logic [FRAME_W-1:0]   frame_number;
   } stage_type;

   // Result record
   typedef struct packed {
      logic                 frame_stepped;
      logic                 prepared;
      logic                 presented;
      logic                 finalized;
      logic [MODE_W-1:0]    pace_mode;
      logic [FPS_W-1:0]     fps_q8;
      logic                 fps_updated;
      logic [FRAME_W-1:0]   frame_number;
   } result_type;

   function automatic logic [5:0] pace_offset(input logic [MODE_W-1:0] mode,
                                              input logic              third);
      logic [5:0] off;
      case (mode)
         MODE_40: off = OFF_40;
         MODE_30: off = third ? OFF_30_B : OFF_30_A;
         default: off = third ? OFF_60_B : OFF_60_A;
      endcase
      return off;
   endfunction

   function automatic logic [MODE_W-1:0] pace_classify(input logic [COUNT_W-1:0] count,
                                                       input logic [COUNT_W-1:0] thr_mid,
                                                       input logic [COUNT_W-1:0] thr_high);
      logic [MODE_W-1:0] m;
      if (count > thr_high) begin
         m = MODE_30;
      end else if (count > thr_mid) begin
         m = MODE_40;
      end else begin
         m = MODE_60;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: design/fpsg_req_if.sv
// ----------------------------------------------------------------------------
// fpsg_req_if: frame loop pass channel
// Valid/ready channel carrying one pass of the frame loop.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpsg_req_if import fpsg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   time_early;
   logic [TIME_W-1:0]   time_late;
   logic [COUNT_W-1:0]  active_objects;
   logic                set_sync;

   modport source (output valid, output time_early, output time_late,
                   output active_objects, output set_sync, input ready);
   modport sink   (input valid, input time_early, input time_late,
                   input active_objects, input set_sync, output ready);
endinterface

`default_nettype wire

// File: design/fpsg_rsp_if.sv
// ----------------------------------------------------------------------------
// fpsg_rsp_if: pass result channel
// Valid/ready channel carrying the outcome of one frame loop pass.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpsg_rsp_if import fpsg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                frame_stepped;
   logic                prepared;
   logic                presented;
   logic                finalized;
   logic [MODE_W-1:0]   pace_mode;
   logic [FPS_W-1:0]    fps_q8;
   logic                fps_updated;
   logic [FRAME_W-1:0]  frame_number;

   modport source (output valid, output frame_stepped, output prepared, output presented,
                   output finalized, output pace_mode, output fps_q8, output fps_updated,
                   output frame_number, input ready);
   modport sink   (input valid, input frame_stepped, input prepared, input presented,
                   input finalized, input pace_mode, input fps_q8, input fps_updated,
                   input frame_number, output ready);
endinterface

`default_nettype wire

// File: design/fpsg_csr_if.sv
// ----------------------------------------------------------------------------
// fpsg_csr_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpsg_csr_if import fpsg_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/frame_pacing_skip_governor.sv
// ----------------------------------------------------------------------------
// frame_pacing_skip_governor: display deadline, frame skip and rate governor
// Decides per frame loop pass whether to step, prepare, present or skip, and
// measures the presented frame rate once per second.
// ----------------------------------------------------------------------------
// Each item on req_chan is one pass of a frame loop and yields exactly one
// item on rsp_chan, in order. The block takes one item every cycle while
// rsp_chan is ready; an item is registered in the decision stage, then the
// rate stage feeds the result register. The rate is set by the decision
// stage, which folds the start lead and the phase offset into a single 32-bit
// deadline add followed by the time compares, and updates all governor state
// but the fps register. The fps multiply by the pacing scale and the divide by
// 17 (done as a reciprocal multiply) sit in the second stage, off the state
// loop. Register writes on csr_chan are always taken; write them only while
// no item is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_skip_governor import fpsg_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   fpsg_req_if.sink    req_chan,
   fpsg_rsp_if.source  rsp_chan,
   fpsg_csr_if.sink    csr_chan
);

   // Configuration
   logic [SKIP_W-1:0]   max_skip_ff;
   logic [COUNT_W-1:0]  thr_mid_ff;
   logic [COUNT_W-1:0]  thr_high_ff;

   // Governor state
   logic                started_ff,    started_in;
   logic                frame_open_ff, frame_open_in;
   logic                was_prep_ff,   was_prep_in;
   logic [TIME_W-1:0]   deadline_ff,   deadline_in;
   logic [PHASE_W-1:0]  phase_ff,      phase_in;
   logic [1:0]          phase3_ff,     phase3_in;   // phase modulo 3
   logic [MODE_W-1:0]   mode_ff,       mode_in;
   logic [SKIP_W-1:0]   skip_ff,       skip_in;
   logic [TIME_W-1:0]   shown_ff,      shown_in;
   logic [TIME_W-1:0]   shown_prev_ff, shown_prev_in;
   logic [TIME_W-1:0]   fps_due_ff,    fps_due_in;
   logic                sync_hold_ff,  sync_hold_in;
   logic [FRAME_W-1:0]  total_ff,      total_in;
   logic [FPS_W-1:0]    fps_ff,        fps_in;

   // Pipeline
   logic                s1_valid_ff,   s1_valid_in;
   stage_type           s1_ff,         s1_in;
   logic                out_valid_ff,  out_valid_in;
   result_type          out_ff,        out_in;

   logic                a_fire;
   logic                out_load;

   // ---------------------------------------------------------------------------
   // Handshake: the result register parts the two sides; stage 1 advances
   // whenever the result register can take its item.
   // ---------------------------------------------------------------------------
   assign out_load          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready    = !s1_valid_ff || out_load;
   assign a_fire            = req_chan.valid && req_chan.ready;
   assign s1_valid_in       = a_fire || (s1_valid_ff && !out_load);
   assign out_valid_in      = out_load || (out_valid_ff && !rsp_chan.ready);
   assign csr_chan.ready    = 1'b1;

   // ---------------------------------------------------------------------------
   // Decision stage
   // ---------------------------------------------------------------------------
   logic [5:0]          step_off;
   logic [7:0]          dl_add;
   logic [TIME_W-1:0]   dl_base;
   logic [TIME_W-1:0]   dl_cur;
   logic [TIME_W-1:0]   due_cur;
   logic [PHASE_W:0]    phase_inc;
   logic                phase_wrap;
   logic [SKIP_W-1:0]   skip_inc;
   logic [MODE_W-1:0]   mode_class;
   logic [TIME_W-1:0]   shown_delta;

   assign step_off   = pace_offset(mode_ff, phase3_ff == 2'd2);
   // Fold the start lead and the phase step into one add on the deadline.
   assign dl_add     = (started_ff ? 8'd0 : START_LEAD)
                     + (frame_open_ff ? 8'd0 : {2'b00, step_off});
   assign dl_base    = started_ff ? deadline_ff : req_chan.time_early;
   assign dl_cur     = dl_base + {{(TIME_W-8){1'b0}}, dl_add};
   assign due_cur    = started_ff ? fps_due_ff : req_chan.time_early + 32'd1;
   assign phase_inc  = {1'b0, phase_ff} + {{PHASE_W{1'b0}}, 1'b1};
   assign phase_wrap = phase_inc >= (PHASE_W+1)'(PHASES);
   assign skip_inc   = skip_ff + 8'd1;
   assign mode_class = pace_classify(req_chan.active_objects, thr_mid_ff, thr_high_ff);

   always_comb begin
      started_in    = started_ff;
      frame_open_in = frame_open_ff;
      was_prep_in   = was_prep_ff;
      deadline_in   = deadline_ff;
      phase_in      = phase_ff;
      phase3_in     = phase3_ff;
      mode_in       = mode_ff;
      skip_in       = skip_ff;
      shown_in      = shown_ff;
      shown_prev_in = shown_prev_ff;
      fps_due_in    = fps_due_ff;
      sync_hold_in  = sync_hold_ff;
      total_in      = total_ff;
      shown_delta   = '0;
      s1_in         = '0;

      if (a_fire) begin
         started_in   = 1'b1;
         deadline_in  = dl_cur;
         fps_due_in   = due_cur;
         sync_hold_in = sync_hold_ff || req_chan.set_sync;

         // New logic frame: advance the phase and decide prepare or skip
         if (!frame_open_ff) begin
            frame_open_in  = 1'b1;
            s1_in.stepped  = 1'b1;
            total_in       = total_ff + 32'd1;
            phase_in       = phase_wrap ? '0 : phase_inc[PHASE_W-1:0];
            phase3_in      = (phase_wrap || phase3_ff == 2'd2) ? 2'd0 : phase3_ff + 2'd1;
            if (req_chan.time_early >= dl_cur) begin
               was_prep_in = 1'b0;
            end else begin
               was_prep_in    = 1'b1;
               s1_in.prepared = 1'b1;
               mode_in        = mode_class;
            end
         end

         // Deadline reached: present, skip or force a draw, then finalize
         if (req_chan.time_late >= dl_cur) begin
            if (was_prep_in) begin
               s1_in.presented = 1'b1;
            end else if (!sync_hold_in) begin
               skip_in = skip_inc;
               if (skip_inc >= max_skip_ff) begin
                  s1_in.prepared  = 1'b1;
                  s1_in.presented = 1'b1;
                  mode_in         = mode_class;
                  skip_in         = '0;
               end
            end
            s1_in.finalized = 1'b1;
            if (s1_in.presented) begin
               shown_in = shown_ff + 32'd1;
            end
            frame_open_in = 1'b0;
            if (req_chan.time_late >= due_cur) begin
               s1_in.fps_upd = 1'b1;
               fps_due_in    = due_cur + FPS_PERIOD;
               shown_prev_in = shown_in;
            end
         end else begin
            sync_hold_in = 1'b0;
         end

         // Frames presented since the last rate window closed
         shown_delta        = shown_in - shown_prev_ff;
         s1_in.mode         = mode_in;
         s1_in.frame_number = total_in;
         s1_in.d_big        = shown_delta >= FPS_SAT_D;
         s1_in.d_small      = shown_delta[FPS_D_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Rate stage: fps = d*a + floor((d*r + 8) / 17), then saturate
   // ---------------------------------------------------------------------------
   logic [8:0]          fps_a;
   logic [16:0]         fps_rem;
   logic [33:0]         fps_div_prod;
   logic [FPS_D_W-1:0]  fps_quot;
   logic [21:0]         fps_full;
   logic [FPS_W-1:0]    fps_new;

   always_comb begin
      case (s1_ff.mode)
         MODE_40: begin
            fps_a   = FPS_A_40;
            fps_rem = {1'b0, s1_ff.d_small, 3'b000} + FPS_ROUND;
         end
         MODE_30: begin
            fps_a   = FPS_A_30;
            fps_rem = {s1_ff.d_small, 4'b0000} + FPS_ROUND;
         end
         default: begin
            fps_a   = FPS_A_60;
            fps_rem = FPS_ROUND;
         end
      endcase
   end

   assign fps_div_prod = fps_rem * FPS_DIV_MUL;
   assign fps_quot     = fps_div_prod[FPS_DIV_SH +: FPS_D_W];
   assign fps_full     = (22'(s1_ff.d_small) * 22'(fps_a)) + 22'(fps_quot);
   assign fps_new      = (s1_ff.d_big || fps_full > 22'(16'hFFFF)) ? 16'hFFFF
                                                                   : fps_full[FPS_W-1:0];

   assign fps_in = (out_load && s1_ff.fps_upd) ? fps_new : fps_ff;

   always_comb begin
      out_in               = out_ff;
      if (out_load) begin
         out_in.frame_stepped = s1_ff.stepped;
         out_in.prepared      = s1_ff.prepared;
         out_in.presented     = s1_ff.presented;
         out_in.finalized     = s1_ff.finalized;
         out_in.pace_mode     = s1_ff.mode;
         out_in.fps_q8        = s1_ff.fps_upd ? fps_new : fps_ff;
         out_in.fps_updated   = s1_ff.fps_upd;
         out_in.frame_number  = s1_ff.frame_number;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_stepped = out_ff.frame_stepped;
   assign rsp_chan.prepared      = out_ff.prepared;
   assign rsp_chan.presented     = out_ff.presented;
   assign rsp_chan.finalized     = out_ff.finalized;
   assign rsp_chan.pace_mode     = out_ff.pace_mode;
   assign rsp_chan.fps_q8        = out_ff.fps_q8;
   assign rsp_chan.fps_updated   = out_ff.fps_updated;
   assign rsp_chan.frame_number  = out_ff.frame_number;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_skip_ff <= MAX_SKIP_RST;
         thr_mid_ff  <= THR_MID_RST;
         thr_high_ff <= THR_HIGH_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAX_SKIP: max_skip_ff <= csr_chan.data[SKIP_W-1:0];
            CSR_THR_MID:  thr_mid_ff  <= csr_chan.data;
            CSR_THR_HIGH: thr_high_ff <= csr_chan.data;
            default: ;   // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         frame_open_ff <= 1'b0;
         was_prep_ff   <= 1'b0;
         deadline_ff   <= '0;
         phase_ff      <= '0;
         phase3_ff     <= '0;
         mode_ff       <= MODE_60;
         skip_ff       <= '0;
         shown_ff      <= '0;
         shown_prev_ff <= '0;
         fps_due_ff    <= '0;
         sync_hold_ff  <= 1'b0;
         total_ff      <= '0;
         fps_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         started_ff    <= started_in;
         frame_open_ff <= frame_open_in;
         was_prep_ff   <= was_prep_in;
         deadline_ff   <= deadline_in;
         phase_ff      <= phase_in;
         phase3_ff     <= phase3_in;
         mode_ff       <= mode_in;
         skip_ff       <= skip_in;
         shown_ff      <= shown_in;
         shown_prev_ff <= shown_prev_in;
         fps_due_ff    <= fps_due_in;
         sync_hold_ff  <= sync_hold_in;
         total_ff      <= total_in;
         fps_ff        <= fps_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         s1_ff <= s1_in;
      end
      out_ff <= out_in;
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && out_valid_ff))
      else $error("input stalled while the pipeline has room");

   a_present_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.presented |-> rsp_chan.finalized)
      else $error("frame presented without finalization");

   a_close_frame: assert property (@(posedge clock) disable iff (reset)
      a_fire && req_chan.time_late >= dl_cur |=> !frame_open_ff)
      else $error("frame left open after its deadline");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (PHASE_W+1)'(phase_ff) < (PHASE_W+1)'(PHASES) && phase3_ff != 2'd3)
      else $error("phase counter out of range");

   a_fps_sat: assert property (@(posedge clock) disable iff (reset)
      out_load && s1_ff.fps_upd && s1_ff.d_big |=> out_ff.fps_q8 == 16'hFFFF)
      else $error("large frame count did not saturate fps");

endmodule

`default_nettype wire
